[rtl/core/cmrr_pkg.sv]
// Shared types and codes for the core mailbox round-robin block.
package cmrr_pkg;

	// Request opcodes; the fourth code is unused and answers all zero
	typedef enum logic [1:0] {
		OP_SEND  = 2'd0,
		OP_RECV  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Request sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_META = 2'd1,
		S_DONE = 2'd2
	} fsm_t;

	// Core index width of the pick result, wide enough for sixteen cores
	localparam int CORE_IDX_W = 4;

	// Round-robin pick result
	typedef struct packed {
		logic                  hit;
		logic [CORE_IDX_W-1:0] src;
	} pick_t;

	// Result fields that do not come from the message store
	typedef struct packed {
		status_t    status;
		logic       got_message;
		logic [1:0] from_core;
		logic       pending;
		logic       wake_valid;
		logic [1:0] wake_core;
	} result_t;

endpackage

[rtl/core/cmrr_meta_mem.sv]
// Per-FIFO pointer and count memory with valid bits and a registered read.
module cmrr_meta_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	// Entry valid bits: an entry never written reads as zero (empty FIFO)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= vld_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

endmodule

[rtl/core/cmrr_msg_mem.sv]
// Message slot store: one write port, one registered read port.
module cmrr_msg_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 96
) (
	input  logic                                   clk,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/cmrr_rr_pick.sv]
// Round-robin source pick over the non-empty FIFOs into one destination.
module cmrr_rr_pick #(
	parameter int MAX_CORES = 4
) (
	input  logic [MAX_CORES-1:0]                              req,
	input  logic [(MAX_CORES > 1 ? $clog2(MAX_CORES) : 1)-1:0] start_raw,
	input  logic [$clog2(MAX_CORES+1)-1:0]                    n,
	output cmrr_pkg::pick_t                                   pick
);
	import cmrr_pkg::*;

	localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int NW = $clog2(MAX_CORES+1);
	localparam int RW = 1 << CW;

	logic [CW-1:0] start;
	logic [RW-1:0] req_ext;
	logic [CW:0]   cand [MAX_CORES];
	logic          found;

	// Small restoring remainder: a stale pointer is folded into the core count
	function automatic logic [CW-1:0] mod_n(input logic [CW-1:0] x,
		input logic [NW-1:0] d);
		logic [NW:0] rem;
		rem = '0;
		for (int i = CW-1; i >= 0; i--) begin
			rem = {rem[NW-1:0], x[i]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
			end
		end
		return CW'(rem);
	endfunction

	// Candidate source for each offset from the start, wrapped at the count
	always_comb begin
		start = mod_n(start_raw, n);
		for (int off = 0; off < MAX_CORES; off++) begin
			cand[off] = (CW+1)'(start) + (CW+1)'(off);
			if (cand[off] >= (CW+1)'(n)) begin
				cand[off] = cand[off] - (CW+1)'(n);
			end
		end
	end

	// First non-empty candidate in round-robin order
	always_comb begin
		req_ext = RW'(req);
		found   = 1'b0;
		pick    = '0;
		for (int off = 0; off < MAX_CORES; off++) begin
			if (!found && (off < int'(n)) && req_ext[cand[off][CW-1:0]]) begin
				found    = 1'b1;
				pick.hit = 1'b1;
				pick.src = CORE_IDX_W'(cand[off][CW-1:0]);
			end
		end
	end

endmodule

[rtl/core/core_mailbox_round_robin_top.sv]
// Top level of the core mailbox round-robin block: request sequencer and result register.
//
// One mailbox FIFO of FIFO_SLOTS messages for every ordered pair of MAX_CORES cores.
// Each request (send, receive or pending query) passes through an accept cycle, which
// picks the receive source and reads the pair's pointer memory, an update cycle, which
// writes pointers and accesses the message store, and a result cycle that loads the
// output register; the next request is taken once the sequencer is back in idle, while
// the previous result may still wait at the output. The registered reads of the pointer
// and message memories set this sequence. The message store is never cleared; pointer
// memory entries carry valid bits that reset clears, so the block takes requests right
// after reset. active_cores may be written only while no request is in flight.
module core_mailbox_round_robin_top #(
	parameter int MAX_CORES  = 4,
	parameter int FIFO_SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_wr_en,
	input  logic [2:0]            cfg_wr_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic [1:0]            src_id,
	input  logic [1:0]            dst_id,
	input  logic [31:0]           msg_tag,
	input  logic [63:0]           payload_word,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic                  got_message,
	output logic [1:0]            from_core,
	output logic [31:0]           out_tag,
	output logic [63:0]           out_payload,
	output logic                  pending,
	output logic                  wake_valid,
	output logic [1:0]            wake_core
);
	import cmrr_pkg::*;

	localparam int PAIRS  = MAX_CORES * MAX_CORES;
	localparam int CW     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int NW     = $clog2(MAX_CORES+1);
	localparam int PW     = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int IW     = (FIFO_SLOTS > 1) ? $clog2(FIFO_SLOTS) : 1;
	localparam int FW     = $clog2(FIFO_SLOTS+1);
	localparam int DEPTH  = PAIRS * FIFO_SLOTS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW     = 96;
	localparam int META_W = 2*IW + FW;
	localparam int NE_W   = 1 << PW;

	// Configuration and control state
	logic [2:0]     active_cores_q;
	fsm_t           state_q, state_nxt;
	logic [PAIRS-1:0] ne_q;
	logic [CW-1:0]  nsrc_q [MAX_CORES];

	// Request pipeline registers
	op_t            op_s1;
	logic [1:0]     src_s1, dst_s1;
	logic [31:0]    tag_s1;
	logic [63:0]    pay_s1;
	pick_t          pick_s1;
	logic [PW-1:0]  pair_s1;
	result_t        res_s2;

	// Output register
	logic           out_valid_q;
	result_t        out_res_q;
	logic [31:0]    out_tag_q;
	logic [63:0]    out_pay_q;

	// Combinational
	logic [NW-1:0]  n_lim;
	logic           in_acc, out_free, out_load;
	logic [CW-1:0]  in_src_c, in_dst_c, dst_s1_c;
	logic [NE_W-1:0] ne_ext;
	logic [MAX_CORES-1:0] rr_req;
	logic [CW-1:0]  rr_start;
	pick_t          pick;
	logic [CW-1:0]  sel_src;
	logic [PW-1:0]  meta_rd_addr;
	logic [META_W-1:0] meta_rd_data, meta_wr_data;
	logic           meta_wr_en;
	logic [IW-1:0]  rd_idx, wr_idx, rd_idx_nxt, wr_idx_nxt;
	logic [FW-1:0]  cnt;
	logic           range_ok, send_ok, pop_ok, any_pending;
	logic           msg_wr_en, msg_rd_en;
	logic [AW-1:0]  msg_wr_addr, msg_rd_addr;
	logic [MW-1:0]  msg_rd_data;
	logic [CW:0]    nsrc_inc;
	result_t        res_nxt;

	// Effective core count: values above the maximum clamp to it
	always_comb begin
		if (int'(active_cores_q) > MAX_CORES) begin
			n_lim = NW'(MAX_CORES);
		end else begin
			n_lim = NW'(active_cores_q);
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cores_q <= 3'd4;
		end else if (cfg_wr_en) begin
			active_cores_q <= cfg_wr_data;
		end
	end

	// Handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;

	// Next-state logic
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_META;
			end
			S_META: state_nxt = S_DONE;
			S_DONE: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			S_IDLE:  in_stall = 1'b0;
			S_META:  in_stall = 1'b1;
			S_DONE:  out_load = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Round-robin request vector and start pointer for the incoming destination
	assign in_src_c = CW'(src_id);
	assign in_dst_c = CW'(dst_id);
	assign ne_ext   = NE_W'(ne_q);

	always_comb begin
		for (int s = 0; s < MAX_CORES; s++) begin
			rr_req[s] = ne_ext[PW'(s*MAX_CORES + int'(in_dst_c))];
		end
		rr_start = (int'(in_dst_c) < MAX_CORES) ? nsrc_q[in_dst_c] : '0;
	end

	cmrr_rr_pick #(
		.MAX_CORES(MAX_CORES)
	) u_pick (
		.req      (rr_req),
		.start_raw(rr_start),
		.n        (n_lim),
		.pick     (pick)
	);

	// Pair address of the FIFO the request touches
	always_comb begin
		sel_src      = (op_t'(op) == OP_SEND) ? in_src_c : CW'(pick.src);
		meta_rd_addr = PW'(int'(sel_src)*MAX_CORES + int'(in_dst_c));
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= op_t'(op);
			src_s1  <= src_id;
			dst_s1  <= dst_id;
			tag_s1  <= msg_tag;
			pay_s1  <= payload_word;
			pick_s1 <= pick;
			pair_s1 <= meta_rd_addr;
		end
	end

	cmrr_meta_mem #(
		.DEPTH(PAIRS),
		.WIDTH(META_W)
	) u_meta (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_acc),
		.rd_addr(meta_rd_addr),
		.rd_data(meta_rd_data),
		.wr_en  (meta_wr_en),
		.wr_addr(pair_s1),
		.wr_data(meta_wr_data)
	);

	// Update stage: range, full and pop decisions
	assign {rd_idx, wr_idx, cnt} = meta_rd_data;
	assign dst_s1_c = CW'(dst_s1);

	always_comb begin
		if (op_s1 == OP_SEND) begin
			range_ok = (int'(src_s1) < int'(n_lim)) && (int'(dst_s1) < int'(n_lim));
		end else begin
			range_ok = int'(dst_s1) < int'(n_lim);
		end
		send_ok = (op_s1 == OP_SEND) && range_ok && (int'(cnt) < FIFO_SLOTS);
		pop_ok  = (op_s1 == OP_RECV) && range_ok && pick_s1.hit;
		rd_idx_nxt = (int'(rd_idx) == FIFO_SLOTS-1) ? '0 : IW'(rd_idx + 1'b1);
		wr_idx_nxt = (int'(wr_idx) == FIFO_SLOTS-1) ? '0 : IW'(wr_idx + 1'b1);
	end

	// Memory writes and reads issued from the update stage
	always_comb begin
		msg_wr_en    = (state_q == S_META) && send_ok;
		msg_rd_en    = (state_q == S_META) && pop_ok;
		msg_wr_addr  = AW'(int'(pair_s1)*FIFO_SLOTS + int'(wr_idx));
		msg_rd_addr  = AW'(int'(pair_s1)*FIFO_SLOTS + int'(rd_idx));
		meta_wr_en   = msg_wr_en || msg_rd_en;
		if (op_s1 == OP_SEND) begin
			meta_wr_data = {rd_idx, wr_idx_nxt, FW'(cnt + 1'b1)};
		end else begin
			meta_wr_data = {rd_idx_nxt, wr_idx, FW'(cnt - 1'b1)};
		end
	end

	cmrr_msg_mem #(
		.DEPTH(DEPTH),
		.WIDTH(MW)
	) u_msg (
		.clk    (clk),
		.rd_en  (msg_rd_en),
		.rd_addr(msg_rd_addr),
		.rd_data(msg_rd_data),
		.wr_en  (msg_wr_en),
		.wr_addr(msg_wr_addr),
		.wr_data({tag_s1, pay_s1})
	);

	// Pending query over the sources in use
	always_comb begin
		any_pending = 1'b0;
		for (int s = 0; s < MAX_CORES; s++) begin
			if ((s < int'(n_lim)) && ne_ext[PW'(s*MAX_CORES + int'(dst_s1_c))]) begin
				any_pending = 1'b1;
			end
		end
	end

	// Result fields formed in the update stage
	always_comb begin
		res_nxt = '0;
		if (!range_ok && (op_s1 inside {OP_SEND, OP_RECV, OP_QUERY})) begin
			res_nxt.status = STAT_RANGE;
		end else begin
			case (op_s1)
				OP_SEND: begin
					if (send_ok) begin
						res_nxt.wake_valid = 1'b1;
						res_nxt.wake_core  = dst_s1;
					end else begin
						res_nxt.status = STAT_FULL;
					end
				end
				OP_RECV: begin
					res_nxt.got_message = pop_ok;
					res_nxt.from_core   = pop_ok ? pick_s1.src[1:0] : 2'd0;
				end
				OP_QUERY: res_nxt.pending = any_pending;
				default:  res_nxt = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_META) begin
			res_s2 <= res_nxt;
		end
	end

	// Non-empty flags and round-robin pointers
	assign nsrc_inc = (CW+1)'(pick_s1.src[CW-1:0]) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
			for (int d = 0; d < MAX_CORES; d++) begin
				nsrc_q[d] <= '0;
			end
		end else if (state_q == S_META) begin
			if (send_ok) begin
				ne_q[pair_s1] <= 1'b1;
			end
			if (pop_ok) begin
				ne_q[pair_s1]     <= (int'(cnt) != 1);
				nsrc_q[dst_s1_c]  <= (nsrc_inc == (CW+1)'(n_lim)) ? '0 : CW'(nsrc_inc);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q <= res_s2;
			out_tag_q <= res_s2.got_message ? msg_rd_data[MW-1:64] : 32'd0;
			out_pay_q <= res_s2.got_message ? msg_rd_data[63:0] : 64'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_res_q.status;
	assign got_message = out_res_q.got_message;
	assign from_core   = out_res_q.from_core;
	assign out_tag     = out_tag_q;
	assign out_payload = out_pay_q;
	assign pending     = out_res_q.pending;
	assign wake_valid  = out_res_q.wake_valid;
	assign wake_core   = out_res_q.wake_core;

	// Memory writes happen only in the update stage
	assert property (@(posedge clk) disable iff (!arst_n)
		meta_wr_en |-> (state_q == S_META))
		else $error("pointer memory written outside the update stage");

	// A pop only ever targets a FIFO flagged non-empty
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_rd_en |-> ne_q[pair_s1])
		else $error("pop from a FIFO flagged empty");

	// A new result appears only from the result stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result register loaded outside the result stage");

	// A FIFO emptied by a pop loses its non-empty flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(msg_rd_en && (int'(cnt) == 1)) |=> !ne_q[$past(pair_s1)])
		else $error("non-empty flag kept after last message popped");

endmodule
